### src/tpst_pkg.sv
// Package for the thruster pulse Schmitt trigger unit.
// Holds field widths, reset values, register indexes, the sequencer state type
// and the divider control struct. No dependencies.
`default_nettype none

package tpst_pkg;

	// Default number of thrusters with stored hysteresis state.
	localparam int THRUSTERS_DEFAULT = 16;

	// Field widths.
	localparam int TIME_W     = 63;
	localparam int IDX_W      = 4;
	localparam int FORCE_W    = 32;
	localparam int ON_W       = 33;
	localparam int LVL_W      = 16;
	localparam int DW         = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_THRUST_STATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_FIRE_TIME_NS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ON          = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_OFF         = 2'd3;

	// Register reset values.
	localparam logic [DW-1:0]    MIN_FIRE_RESET  = 32'd20000000;
	localparam logic [LVL_W-1:0] LEVEL_ON_RESET  = 16'd49152;
	localparam logic [LVL_W-1:0] LEVEL_OFF_RESET = 16'd16384;

	// On-time given in off-pulsing mode during the first control step.
	localparam logic [ON_W-1:0] FIRST_STEP_NS = 33'd2000000000;

	// floor(1.1 * p) is computed as p + floor(p / SAT_DIVISOR).
	localparam logic [DW-1:0] SAT_DIVISOR = 32'd10;

	typedef enum logic [3:0] {
		S_IDLE,
		S_STEP,
		S_MUL,
		S_DCHK,
		S_DIV,
		S_CLS,
		S_LVL1,
		S_LVL2,
		S_LVL3,
		S_SATDIV,
		S_SATFIN,
		S_DONE
	} tpst_state_t;

	typedef struct packed {
		logic load;
		logic run;
	} div_ctl_t;

endpackage

`default_nettype wire

### src/tpst_if.sv
// Channel interfaces of the thruster pulse Schmitt trigger unit: command,
// result and configuration write. Depends on tpst_pkg for the field widths.
`default_nettype none

interface tpst_cmd_if import tpst_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      step_start;
	logic [TIME_W-1:0]         call_time_ns;
	logic [IDX_W-1:0]          thruster_index;
	logic signed [FORCE_W-1:0] force_cmd;
	logic [FORCE_W-1:0]        max_thrust;

	modport source (output valid, step_start, call_time_ns, thruster_index, force_cmd,
		max_thrust, input ready);
	modport sink (input valid, step_start, call_time_ns, thruster_index, force_cmd,
		max_thrust, output ready);
endinterface

interface tpst_res_if import tpst_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] thruster_index_out;
	logic [ON_W-1:0]  on_time_ns;
	logic             thruster_on;
	logic             first_step;

	modport source (output valid, thruster_index_out, on_time_ns, thruster_on, first_step,
		input ready);
	modport sink (input valid, thruster_index_out, on_time_ns, thruster_on, first_step,
		output ready);
endinterface

interface tpst_cfg_if import tpst_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/thruster_pulse_schmitt_trigger_unit.sv
// Thruster pulse-width modulator with Schmitt-trigger hysteresis, top level.
// Depends on tpst_pkg, the channel interfaces, tpst_ram and tpst_sdiv.
`default_nettype none

// Each command transaction carries one thruster's force for a control step and
// yields exactly one result transaction. The first command of a step marks
// step_start and sets the control period from the previous call time; the very
// first step reports the base on-time in off-pulsing mode and zero otherwise.
// Otherwise the force (plus maximum thrust in off-pulsing mode, then clamped at
// zero) is turned into on_time = force * period / max_thrust with a bit-serial
// shift-add multiplier followed by a bit-serial restoring divider. Short
// requests pass a per-thruster hysteresis on level_on and level_off that snaps
// them to the minimum fire time or to zero; requests of a full period or more
// become floor(1.1 * period), found by a second pass of the same divider. One
// command is worked on at a time. The finished result sits in an output
// register, so the next command can be taken while the result waits. Hysteresis
// state lives in a small RAM with one valid bit per thruster, cleared at once by
// reset. Indexes at or above THRUSTERS read as off and never update the stored
// state. Configuration writes are always accepted and must only be issued while
// no command is in flight.
module thruster_pulse_schmitt_trigger_unit import tpst_pkg::*; #(
	parameter int THRUSTERS = THRUSTERS_DEFAULT
) (
	input wire logic  clk,
	input wire logic  arst_n,
	tpst_cmd_if.sink  cmd,
	tpst_res_if.source res,
	tpst_cfg_if.sink  cfg
);

	localparam int AW    = (THRUSTERS > 1) ? $clog2(THRUSTERS) : 1;
	localparam int CNT_W = $clog2(DW);

	// Sequencer state and iteration counter.
	tpst_state_t      state_q;
	tpst_state_t      state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             cnt_last;

	// Configuration registers.
	logic             base_q;
	logic [DW-1:0]    minf_q;
	logic [LVL_W-1:0] lon_q;
	logic [LVL_W-1:0] loff_q;

	// Control-step state.
	logic [TIME_W-1:0] prev_q;
	logic [DW-1:0]     period_q;
	logic              first_q;
	logic [THRUSTERS-1:0] vld_q;

	// Captured command.
	logic              step_q;
	logic [TIME_W-1:0] t_q;
	logic [IDX_W-1:0]  idx_q;
	logic [AW-1:0]     addr_q;
	logic              idx_ok_q;
	logic [DW-2:0]     f_q;
	logic [DW-1:0]     maxt_q;
	logic              st_q;

	// Working datapath.
	logic [2*DW-1:0]       acc_q;
	logic [DW-1:0]         mp_q;
	logic [LVL_W+DW-1:0]   prod_q;
	logic                  ge_q;
	logic [ON_W-1:0]       res_on_q;
	logic                  res_st_q;
	logic                  res_first_q;

	// Output register.
	logic             out_valid_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [ON_W-1:0]  out_on_q;
	logic             out_st_q;
	logic             out_first_q;

	// Combinational helpers.
	logic                 accept;
	logic                 fire_out;
	logic [AW+IDX_W-1:0]  idx_ext;
	logic [AW-1:0]        cmd_addr;
	logic                 cmd_idx_ok;
	logic signed [DW+1:0] fsum;
	logic [DW+1:0]        fsel;
	logic [DW-2:0]        f_c;
	logic [2*DW-1:0]      tdiff;
	logic                 first_d;
	logic [DW-1:0]        period_d;
	logic [DW:0]          mul_sum;
	logic                 ovf_c;
	logic                 below_c;
	logic                 sat_c;
	logic                 sat_sel;
	logic [LVL_W-1:0]     lvl_sel;
	logic [LVL_W+DW-1:0]  lvl_prod;
	logic [LVL_W+DW-1:0]  lvl_on_time;
	logic                 ram_rdata;
	logic                 ram_we;
	logic                 st_rd;
	div_ctl_t             div_ctl;
	logic [DW-1:0]        div_rem;
	logic [DW-1:0]        div_num;
	logic [DW-1:0]        div_den;
	logic [DW-1:0]        quo;

	assign accept   = cmd.valid && cmd.ready;
	assign fire_out = (state_q == S_DONE) && (!out_valid_q || res.ready);
	assign cnt_last = (cnt_q == {CNT_W{1'b1}});

	// Thruster index to RAM address; indexes past the table never touch it.
	assign idx_ext    = {{AW{1'b0}}, cmd.thruster_index};
	assign cmd_addr   = idx_ext[AW-1:0];
	assign cmd_idx_ok = (32'(cmd.thruster_index) < THRUSTERS);

	// Off-pulsing adds the maximum thrust; the result saturates high and clamps at zero.
	assign fsum = {{2{cmd.force_cmd[FORCE_W-1]}}, cmd.force_cmd} +
		$signed({2'b00, cmd.max_thrust});
	assign fsel = base_q ? fsum : {{2{cmd.force_cmd[FORCE_W-1]}}, cmd.force_cmd};
	always_comb begin
		if (fsel[DW+1]) begin
			f_c = '0;
		end else if (fsel[DW:DW-1] != 2'b00) begin
			f_c = '1;
		end else begin
			f_c = fsel[DW-2:0];
		end
	end

	// Period update at a step start: wrap-around difference, saturated to 32 bits.
	assign tdiff = {1'b0, t_q} - {1'b0, prev_q};
	always_comb begin
		first_d  = first_q;
		period_d = period_q;
		if (step_q) begin
			if (prev_q == '0) begin
				first_d = 1'b1;
			end else begin
				first_d  = 1'b0;
				period_d = (tdiff[2*DW-1:DW] != '0) ? '1 : tdiff[DW-1:0];
			end
		end
	end

	assign st_rd   = idx_ok_q && vld_q[addr_q] && ram_rdata;
	assign mul_sum = {1'b0, acc_q[2*DW-1:DW]} + (mp_q[0] ? {2'b00, f_q} : '0);

	// A high product word at or above the divisor means the quotient is at least 2^32.
	assign ovf_c   = (acc_q[2*DW-1:DW] >= maxt_q);
	assign below_c = (quo < minf_q);
	assign sat_c   = (quo >= period_q);
	assign sat_sel = ((state_q == S_DCHK) && ovf_c) ||
		((state_q == S_CLS) && !below_c && sat_c);

	assign lvl_sel     = (state_q == S_LVL1) ? lon_q : loff_q;
	assign lvl_prod    = lvl_sel * minf_q;
	assign lvl_on_time = {quo, {LVL_W{1'b0}}};

	always_comb begin
		div_rem = sat_sel ? '0 : acc_q[2*DW-1:DW];
		div_num = sat_sel ? period_q : acc_q[DW-1:0];
		div_den = sat_sel ? SAT_DIVISOR : maxt_q;
	end

	// Next state and control outputs.
	always_comb begin
		state_d   = state_q;
		div_ctl   = '0;
		cmd.ready = 1'b0;
		ram_we    = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				state_d = first_d ? S_DONE : S_MUL;
			end
			S_MUL: begin
				if (cnt_last) begin
					state_d = S_DCHK;
				end
			end
			S_DCHK: begin
				div_ctl.load = 1'b1;
				state_d      = ovf_c ? S_SATDIV : S_DIV;
			end
			S_DIV: begin
				div_ctl.run = 1'b1;
				if (cnt_last) begin
					state_d = S_CLS;
				end
			end
			S_CLS: begin
				if (below_c) begin
					state_d = S_LVL1;
				end else if (sat_c) begin
					div_ctl.load = 1'b1;
					state_d      = S_SATDIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_LVL1: state_d = S_LVL2;
			S_LVL2: state_d = S_LVL3;
			S_LVL3: state_d = S_DONE;
			S_SATDIV: begin
				div_ctl.run = 1'b1;
				if (cnt_last) begin
					state_d = S_SATFIN;
				end
			end
			S_SATFIN: state_d = S_DONE;
			S_DONE: begin
				if (fire_out) begin
					ram_we  = idx_ok_q;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration, step state, valid bits and the output handshake.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= 1'b0;
			minf_q      <= MIN_FIRE_RESET;
			lon_q       <= LEVEL_ON_RESET;
			loff_q      <= LEVEL_OFF_RESET;
			prev_q      <= '0;
			period_q    <= '0;
			first_q     <= 1'b0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_BASE_THRUST_STATE: base_q <= cfg.data[0];
					CFG_MIN_FIRE_TIME_NS:  minf_q <= cfg.data;
					CFG_LEVEL_ON:          lon_q  <= cfg.data[LVL_W-1:0];
					CFG_LEVEL_OFF:         loff_q <= cfg.data[LVL_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_STEP) begin
				first_q  <= first_d;
				period_q <= period_d;
				if (step_q) begin
					prev_q <= t_q;
				end
			end
			if (ram_we) begin
				vld_q[addr_q] <= 1'b1;
			end
			if (fire_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers; none of them needs a reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			step_q   <= cmd.step_start;
			t_q      <= cmd.call_time_ns;
			idx_q    <= cmd.thruster_index;
			addr_q   <= cmd_addr;
			idx_ok_q <= cmd_idx_ok;
			f_q      <= f_c;
			// A zero maximum thrust counts as one Q16.16 step.
			maxt_q   <= (cmd.max_thrust == '0) ? {{(DW-1){1'b0}}, 1'b1} : cmd.max_thrust;
		end
		case (state_q)
			S_STEP: begin
				st_q  <= st_rd;
				cnt_q <= '0;
				acc_q <= '0;
				mp_q  <= period_d;
				if (first_d) begin
					res_on_q    <= base_q ? FIRST_STEP_NS : '0;
					res_st_q    <= st_rd;
					res_first_q <= 1'b1;
				end else begin
					res_first_q <= 1'b0;
				end
			end
			S_MUL: begin
				acc_q <= {mul_sum, acc_q[DW-1:1]};
				mp_q  <= {1'b0, mp_q[DW-1:1]};
				cnt_q <= cnt_q + 1'b1;
			end
			S_DCHK: begin
				cnt_q <= '0;
				if (ovf_c) begin
					res_st_q <= 1'b1;
				end
			end
			S_DIV, S_SATDIV: begin
				cnt_q <= cnt_q + 1'b1;
			end
			S_CLS: begin
				cnt_q <= '0;
				if (!below_c) begin
					res_st_q <= 1'b1;
					res_on_q <= {1'b0, quo};
				end
			end
			S_LVL1: begin
				prod_q <= lvl_prod;
			end
			S_LVL2: begin
				ge_q   <= (lvl_on_time >= prod_q);
				prod_q <= lvl_prod;
			end
			S_LVL3: begin
				// Hysteresis: switch on at or above level_on, off at or below level_off, else hold.
				if (ge_q) begin
					res_on_q <= {1'b0, minf_q};
					res_st_q <= 1'b1;
				end else if (lvl_on_time <= prod_q) begin
					res_on_q <= '0;
					res_st_q <= 1'b0;
				end else begin
					res_on_q <= st_q ? {1'b0, minf_q} : '0;
					res_st_q <= st_q;
				end
			end
			S_SATFIN: begin
				res_on_q <= {1'b0, period_q} + {1'b0, quo};
			end
			default: ;
		endcase
		if (fire_out) begin
			out_idx_q   <= idx_q;
			out_on_q    <= res_on_q;
			out_st_q    <= res_st_q;
			out_first_q <= res_first_q;
		end
	end

	tpst_ram #(
		.WIDTH(1),
		.DEPTH(THRUSTERS)
	) u_state_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_q),
		.wdata(res_st_q),
		.raddr(cmd_addr),
		.rdata(ram_rdata)
	);

	tpst_sdiv u_sdiv (
		.clk     (clk),
		.ctl     (div_ctl),
		.rem_init(div_rem),
		.num     (div_num),
		.den     (div_den),
		.quo     (quo)
	);

	assign res.valid              = out_valid_q;
	assign res.thruster_index_out = out_idx_q;
	assign res.on_time_ns         = out_on_q;
	assign res.thruster_on        = out_st_q;
	assign res.first_step         = out_first_q;

	// A result only appears as the sequencer leaves its final state.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result transaction raised outside the done state");

	// A first-step result carries either zero or the base on-time.
	a_first_step_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_first_q |-> (out_on_q == '0 || out_on_q == FIRST_STEP_NS))
		else $error("first-step result with an unexpected on-time");

	// Outside the first step a thruster reported off never gets on-time.
	a_off_means_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_first_q && !out_st_q |-> out_on_q == '0)
		else $error("thruster reported off with nonzero on-time");

	// Commands are only taken while the sequencer is idle.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_STEP)
		else $error("command transaction accepted while busy");

endmodule

`default_nettype wire

### src/tpst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module tpst_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### src/tpst_sdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle while run is set.
// Depends on tpst_pkg for the data width and the control struct.
`default_nettype none

module tpst_sdiv import tpst_pkg::*; (
	input  wire logic          clk,
	input  wire div_ctl_t      ctl,
	input  wire logic [DW-1:0] rem_init,
	input  wire logic [DW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [DW-1:0] quo
);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] lo_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          qbit;

	// The partial remainder stays below the divisor, so the trial value fits DW+1 bits.
	assign trial = {rem_q, lo_q[DW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = ~diff[DW];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= rem_init;
			lo_q  <= num;
			den_q <= den;
		end else if (ctl.run) begin
			rem_q <= qbit ? diff[DW-1:0] : trial[DW-1:0];
			lo_q  <= {lo_q[DW-2:0], qbit};
		end
	end

	assign quo = lo_q;

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for thruster_pulse_schmitt_trigger_unit: directed and random
// force commands, register writes between phases, results checked against a predictor or typed-in values.
// Depends on tpst_pkg, the channel interfaces in tpst_if and the unit itself.

module testbench;
	import tpst_pkg::*;

	localparam int NUM_THR     = THRUSTERS_DEFAULT;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int HOLD_CYCLES = 600;
	localparam int TAIL_CYCLES = 150;
	localparam int SETTLE      = 2;

	// One command transaction as the sender sees it. The force is kept as raw bits and
	// sign-extended where the arithmetic needs it.
	typedef struct packed {
		logic                 start;
		logic [TIME_W-1:0]    call_t;
		logic [IDX_W-1:0]     thr;
		logic [FORCE_W-1:0]   frc;
		logic [FORCE_W-1:0]   tmax;
	} cmd_t;

	// One result transaction, in the order of the result channel fields.
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [ON_W-1:0]  on_ns;
		logic             on;
		logic             fs;
	} pulse_t;

	// A line of the directed plan: either a register write or a command. Commands whose
	// result is obvious carry it typed in; the rest are checked against the predictor.
	typedef struct {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		cmd_t                  cmd;
		logic                  typed;
		pulse_t                want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	tpst_cmd_if cmd_ch ();
	tpst_res_if res_ch ();
	tpst_cfg_if cfg_ch ();

	thruster_pulse_schmitt_trigger_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state: per-thruster hysteresis, step timing and the register copies.
	logic        thr_fired [NUM_THR];
	logic [63:0] last_call_ns;
	logic [31:0] period_ns;
	logic        in_first;
	logic        off_pulsing;
	logic [31:0] min_fire_ns;
	logic [15:0] lvl_on;
	logic [15:0] lvl_off;

	pulse_t    pending_pulses [$];
	plan_row_t plan [$];
	pulse_t    want_p;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_trig;
	int hold_seen;
	int hold_left;
	int mismatches;
	int cycle_count;

	// Generator view of the control-step timeline used to aim forces at the hysteresis.
	logic [62:0] gen_time;
	logic [63:0] gen_period;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Work out the result of one accepted command and advance the predictor state.
	function automatic pulse_t predict_pulse(input cmd_t c);
		pulse_t r;
		logic [63:0] t, d, f, div, on, lvl, per, minf;
		logic signed [63:0] net_force;
		logic addr_ok, st;
		addr_ok = c.thr < NUM_THR;
		st = addr_ok ? thr_fired[c.thr] : 1'b0;
		if (c.start) begin
			t = {1'b0, c.call_t};
			if (last_call_ns == 64'd0) begin
				// No earlier call time is known yet, so this step only reports the base state.
				last_call_ns = t;
				in_first = 1'b1;
			end else begin
				// The difference wraps, so a call time that goes backwards saturates too.
				d = t - last_call_ns;
				period_ns = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
				last_call_ns = t;
				in_first = 1'b0;
			end
		end
		r.idx = c.thr;
		if (in_first) begin
			r.on_ns = off_pulsing ? FIRST_STEP_NS : '0;
			r.on = st;
			r.fs = 1'b1;
			return r;
		end
		net_force = {{32{c.frc[31]}}, c.frc};
		if (off_pulsing) begin
			net_force = net_force + $signed({32'd0, c.tmax});
			if (net_force > 64'sh7FFF_FFFF)
				net_force = 64'sh7FFF_FFFF;
		end
		if (net_force < 0)
			net_force = 0;
		f = net_force;
		div = (c.tmax == '0) ? 64'd1 : {32'd0, c.tmax};
		per = {32'd0, period_ns};
		minf = {32'd0, min_fire_ns};
		on = f * per / div;
		// The short-pulse test comes first, even when the minimum exceeds the period.
		if (on < minf) begin
			lvl = on << 16;
			if (lvl >= {48'd0, lvl_on} * minf) begin
				st = 1'b1;
				on = minf;
			end else if (lvl <= {48'd0, lvl_off} * minf) begin
				st = 1'b0;
				on = 64'd0;
			end else begin
				on = st ? minf : 64'd0;
			end
		end else if (on >= per) begin
			st = 1'b1;
			on = per * 11 / 10;
		end else begin
			st = 1'b1;
		end
		if (addr_ok)
			thr_fired[c.thr] = st;
		r.on_ns = on[ON_W-1:0];
		r.on = st;
		r.fs = 1'b0;
		return r;
	endfunction

	function automatic void cmd_row(input logic s, input logic [TIME_W-1:0] t,
			input logic [IDX_W-1:0] n, input logic [31:0] f, input logic [31:0] m);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.reg_idx = '0;
		row.reg_val = '0;
		row.cmd = {s, t, n, f, m};
		row.typed = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endfunction

	function automatic void typed_row(input logic s, input logic [TIME_W-1:0] t,
			input logic [IDX_W-1:0] n, input logic [31:0] f, input logic [31:0] m,
			input logic [ON_W-1:0] on_ns, input logic st, input logic fs);
		plan_row_t row;
		cmd_row(s, t, n, f, m);
		row = plan.pop_back();
		row.typed = 1'b1;
		row.want = {n, on_ns, st, fs};
		plan.push_back(row);
	endfunction

	function automatic void cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		plan_row_t row;
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		row.cmd = '0;
		row.typed = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endfunction

	// Offer one command, with a random gap before it, and record its expected result once
	// the transaction completes. Valid stays high afterwards so that back-to-back commands
	// follow without a gap; drain() lowers it.
	task automatic send_cmd(input cmd_t c, input logic typed, input pulse_t want);
		pulse_t p;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.step_start <= c.start;
		cmd_ch.call_time_ns <= c.call_t;
		cmd_ch.thruster_index <= c.thr;
		cmd_ch.force_cmd <= c.frc;
		cmd_ch.max_thrust <= c.tmax;
		do @(posedge clk); while (!cmd_ch.ready);
		p = predict_pulse(c);
		pending_pulses.push_back(typed ? want : p);
	endtask

	// Stop offering commands and wait until every outstanding result has been taken.
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (pending_pulses.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Register writes happen only with the unit empty.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_BASE_THRUST_STATE: off_pulsing = val[0];
			CFG_MIN_FIRE_TIME_NS:  min_fire_ns = val;
			CFG_LEVEL_ON:          lvl_on = val[15:0];
			CFG_LEVEL_OFF:         lvl_off = val[15:0];
			default: ;
		endcase
	endtask

	// Random traffic. Most of it is well-formed control steps of one to four thrusters
	// with forces aimed around the minimum fire time or the period, so that the
	// hysteresis and the over-saturation are reached often. The rest is raw noise,
	// call times that restart the first step, and call times that run backwards.
	task automatic run_random(input int n_items);
		int sent, k, nthr, roll, sel;
		cmd_t c;
		logic [62:0] t;
		logic [63:0] tgt;
		logic signed [63:0] aim;
		sent = 0;
		while (sent < n_items) begin
			roll = $urandom_range(99);
			if (roll == 0)
				drain();
			if (roll < 6) begin
				c.start = $urandom_range(1);
				c.call_t = {$urandom, $urandom};
				c.thr = $urandom_range(15);
				c.frc = $urandom;
				c.tmax = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
				if (c.start) begin
					gen_time = c.call_t;
					gen_period = 64'hFFFF_FFFF;
				end
				send_cmd(c, 1'b0, '0);
				sent++;
			end else begin
				if (roll < 9) begin
					// A zero call time makes the following step a first step again.
					t = '0;
					gen_period = 64'hFFFF_FFFF;
				end else if (roll < 12) begin
					t = gen_time >> 1;
					gen_period = 64'hFFFF_FFFF;
				end else begin
					sel = $urandom_range(19);
					if (sel == 0)
						gen_period = $urandom_range(1000, 1);
					else if (sel == 1)
						gen_period = {32'd0, $urandom} * $urandom_range(3, 1);
					else
						gen_period = $urandom_range(200_000_000, 1_000_000);
					t = gen_time + gen_period[62:0];
				end
				gen_time = t;
				nthr = $urandom_range(4, 1);
				for (k = 0; k < nthr && sent < n_items; k++) begin
					c.start = (k == 0);
					c.call_t = (k == 0) ? t : {$urandom, $urandom};
					// A few thrusters get most commands so their hysteresis has a history.
					c.thr = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3);
					c.tmax = ($urandom_range(19) == 0) ? $urandom
						: $urandom_range(32'h0020_0000, 1);
					sel = $urandom_range(9);
					if (sel < 6)
						tgt = {32'd0, min_fire_ns} * $urandom_range(300) / 200;
					else if (sel < 8)
						tgt = gen_period * $urandom_range(130, 70) / 100;
					else
						tgt = $urandom_range(1000);
					aim = tgt * c.tmax / ((gen_period == 0) ? 64'd1 : gen_period);
					aim = aim + $urandom_range(4) - 2;
					if (off_pulsing)
						aim = aim - c.tmax;
					if (aim > 64'sh7FFF_FFFF)
						aim = 64'sh7FFF_FFFF;
					else if (aim < -64'sh8000_0000)
						aim = -64'sh8000_0000;
					c.frc = aim[31:0];
					send_cmd(c, 1'b0, '0);
					sent++;
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// Result checker: every result transaction is matched against the oldest expectation.
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready) begin
			if (pending_pulses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result for thruster %0d arrived with nothing pending",
						res_ch.thruster_index_out);
			end else begin
				want_p = pending_pulses.pop_front();
				check_field("thruster_index_out", want_p.idx, res_ch.thruster_index_out);
				check_field("on_time_ns", want_p.on_ns, res_ch.on_time_ns);
				check_field("thruster_on", want_p.on, res_ch.thruster_on);
				check_field("first_step", want_p.fs, res_ch.first_step);
			end
		end
	end

	// Result receiver. It stalls at random at the current rate, and whenever the stimulus
	// bumps hold_trig it holds ready low for a long stretch so the unit backs up.
	initial begin
		hold_seen = 0;
		hold_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (hold_seen != hold_trig) begin
				hold_seen = hold_trig;
				hold_left = HOLD_CYCLES;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run exceeded %0d cycles", CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int i, blk, sel;
		logic [31:0] fire, on_lvl, off_lvl;

		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.step_start <= 1'b0;
		cmd_ch.call_time_ns <= '0;
		cmd_ch.thruster_index <= '0;
		cmd_ch.force_cmd <= '0;
		cmd_ch.max_thrust <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;

		for (i = 0; i < NUM_THR; i++)
			thr_fired[i] = 1'b0;
		last_call_ns = '0;
		period_ns = '0;
		in_first = 1'b0;
		off_pulsing = 1'b0;
		min_fire_ns = MIN_FIRE_RESET;
		lvl_on = LEVEL_ON_RESET;
		lvl_off = LEVEL_OFF_RESET;
		mismatches = 0;
		hold_trig = 0;
		gen_time = '0;
		gen_period = 64'd100_000_000;
		send_idle_pct = 36;
		recv_idle_pct = 80;

		// Directed plan, under the reset register values at first.
		// A command ahead of any step start works with a zero period and stays off.
		typed_row(1'b0, 63'd0, 4'd0, 32'd100, 32'd1, 33'd0, 1'b0, 1'b0);
		// A zero call time leaves the previous time at zero, so the next step is first too.
		typed_row(1'b1, 63'd0, 4'd1, 32'd5, 32'd7, 33'd0, 1'b0, 1'b1);
		typed_row(1'b1, 63'd1_000_000_000, 4'd2, 32'h7FFF_FFFF, 32'd1, 33'd0, 1'b0, 1'b1);
		typed_row(1'b0, 63'h7FFF_FFFF_FFFF_FFFF, 4'd15, 32'h8000_0000, 32'd0,
			33'd0, 1'b0, 1'b1);
		// A 100 ms period from here on. Full force saturates to 1.1 times the period.
		typed_row(1'b1, 63'd1_100_000_000, 4'd1, 32'h7FFF_FFFF, 32'h0001_0000,
			33'd110_000_000, 1'b1, 1'b0);
		// The most negative force clamps to zero.
		typed_row(1'b0, 63'd0, 4'd2, 32'h8000_0000, 32'hFFFF_FFFF, 33'd0, 1'b0, 1'b0);
		// Half thrust gives half the period, above the minimum fire time.
		typed_row(1'b0, 63'd0, 4'd3, 32'h0000_8000, 32'h0001_0000, 33'd50_000_000, 1'b1, 1'b0);
		// A zero maximum thrust counts as the smallest step.
		typed_row(1'b0, 63'd0, 4'd4, 32'd1, 32'd0, 33'd110_000_000, 1'b1, 1'b0);
		// Hysteresis walk on one thruster: middle band while off, switch on, middle band
		// while on, switch off.
		cmd_row(1'b0, 63'd0, 4'd5, 32'd6554, 32'h0001_0000);
		cmd_row(1'b0, 63'd0, 4'd5, 32'd10000, 32'h0001_0000);
		cmd_row(1'b0, 63'd0, 4'd5, 32'd6554, 32'h0001_0000);
		cmd_row(1'b0, 63'd0, 4'd5, 32'd2000, 32'h0001_0000);
		// On-times exactly at the switch-on and at the switch-off level.
		cmd_row(1'b0, 63'd0, 4'd6, 32'd15, 32'd100);
		cmd_row(1'b0, 63'd0, 4'd6, 32'd5, 32'd100);
		// A call time that goes backwards, then the largest call time: saturated periods.
		cmd_row(1'b1, 63'd500, 4'd7, 32'd1, 32'd1);
		cmd_row(1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 4'd8, 32'd0, 32'hFFFF_FFFF);
		// Off-pulsing with the widest minimum fire time and extreme levels.
		cfg_row(CFG_BASE_THRUST_STATE, 32'd1);
		cfg_row(CFG_MIN_FIRE_TIME_NS, 32'hFFFF_FFFF);
		cfg_row(CFG_LEVEL_ON, 32'd65535);
		cfg_row(CFG_LEVEL_OFF, 32'd0);
		// A zero call time clears the previous time; the step after it is a first step.
		cmd_row(1'b1, 63'd0, 4'd9, 32'hFFFF_FFFF, 32'h0001_0000);
		typed_row(1'b1, 63'd3_000_000_000, 4'd10, 32'd123, 32'd456,
			33'd2_000_000_000, 1'b0, 1'b1);
		typed_row(1'b0, 63'd0, 4'd1, 32'd0, 32'd1, 33'd2_000_000_000, 1'b1, 1'b1);
		// 50 ms period, below the minimum fire time; the added force saturates.
		cmd_row(1'b1, 63'd3_050_000_000, 4'd11, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		cmd_row(1'b0, 63'd0, 4'd12, 32'h8000_0000, 32'h8000_0000);
		// Narrowest minimum fire time with the levels swapped to the other extremes.
		cfg_row(CFG_MIN_FIRE_TIME_NS, 32'd1);
		cfg_row(CFG_LEVEL_ON, 32'd0);
		cfg_row(CFG_LEVEL_OFF, 32'd65535);
		cfg_row(CFG_BASE_THRUST_STATE, 32'd0);
		cmd_row(1'b0, 63'd0, 4'd13, 32'd0, 32'd1);
		cmd_row(1'b0, 63'd0, 4'd14, 32'd1, 32'h0001_0000);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			else
				send_cmd(plan[i].cmd, plan[i].typed, plan[i].want);
		end

		// Six random phases: two with a slow receiver, two with a slow sender, two with
		// no idling at all. Each starts from a fresh register setting, and every second
		// one opens with a long receiver hold-off while commands keep coming.
		for (blk = 0; blk < 6; blk++) begin
			if (blk < 2) begin
				send_idle_pct = 36;
				recv_idle_pct = 80;
			end else if (blk < 4) begin
				send_idle_pct = 80;
				recv_idle_pct = 36;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(CFG_BASE_THRUST_STATE, $urandom_range(1));
			sel = $urandom_range(9);
			if (sel == 0)
				fire = 32'd1;
			else if (sel == 1)
				fire = 32'hFFFF_FFFF;
			else if (sel == 2)
				fire = $urandom | 32'd1;
			else
				fire = $urandom_range(60_000_000, 1_000_000);
			write_reg(CFG_MIN_FIRE_TIME_NS, fire);
			sel = $urandom_range(9);
			if (sel == 0)
				on_lvl = 32'd0;
			else if (sel == 1)
				on_lvl = 32'd65535;
			else
				on_lvl = $urandom_range(65535, 20000);
			write_reg(CFG_LEVEL_ON, on_lvl);
			sel = $urandom_range(9);
			if (sel == 0)
				off_lvl = 32'd0;
			else if (sel == 1)
				off_lvl = 32'd65535;
			else if (sel == 2)
				off_lvl = $urandom_range(65535);
			else
				off_lvl = $urandom_range(on_lvl);
			write_reg(CFG_LEVEL_OFF, off_lvl);
			if (blk % 2 == 1)
				hold_trig++;
			run_random(317);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_pulses.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
